>>> rtl/core/tkss_pkg.sv
// Shared types, constants and state encoding for the two-key sorted table search.
package tkss_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int ENTRY_W     = 2 * KEY_WIDTH;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [POS_W-1:0]     pos_t;
    // Primary key in the upper half, so an unsigned compare is lexicographic.
    typedef logic [ENTRY_W-1:0]   entry_t;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/tkss_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface tkss_req_if import tkss_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    addr_t entry_index;
    key_t  primary_key;
    key_t  secondary_key;

    modport source (output valid, cmd, entry_index, primary_key, secondary_key,
                    input ready);
    modport sink   (input valid, cmd, entry_index, primary_key, secondary_key,
                    output ready);
endinterface

interface tkss_rsp_if import tkss_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    pos_t position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

>>> rtl/core/two_key_sorted_table_search_top.sv
// Top level of the two-key sorted table search: entry memory, probe sequencer, result register.
// Each probe waits on the previous compare, since that compare decides the address of the
// next probe, and the result is registered once the probes are done. A new search transaction
// is accepted only after the last one has loaded its result and the sequencer is back in idle.
// A write transaction gives no result.
// Reset clears the sequencer state, the result valid flag and entries_reg, but not the entry memory.
module two_key_sorted_table_search_top import tkss_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    tkss_req_if.sink    req,
    tkss_rsp_if.source  rsp
);

    // The table lives in one synchronous memory, both keys side by side in each word.
    // Writes come only from accepted write transactions in the idle state, while reads
    // come only from a running search, so the two never touch the same entry in one
    // cycle and no forwarding is needed.
    entry_t entry_mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic   rd_en;
    addr_t  rd_addr;
    logic   wr_en;

    // Configuration register: number of entries covered by a search.
    pos_t   entries_reg;

    // Search state.
    state_t state_reg, state_next;
    entry_t key_reg, key_next;
    pos_t   lo_reg, lo_next;
    pos_t   hi_reg, hi_next;
    addr_t  mid_reg, mid_next;
    logic   hit_reg, hit_next;

    // Result register that decouples the response channel from the search.
    logic   out_valid_reg;
    logic   found_reg;
    pos_t   position_reg;
    logic   load_out;

    // Helpers for the probe step.
    pos_t              len;
    logic              accept;
    logic              entry_le;
    logic              entry_eq;
    pos_t              lo_probe;
    pos_t              hi_probe;
    logic [POS_W:0]    mid_sum;

    assign accept = req.valid && req.ready;
    assign wr_en  = accept && (req.cmd == CMD_WRITE);

    // A count beyond the table depth covers the whole table.
    assign len = (entries_reg > pos_t'(TABLE_DEPTH)) ? pos_t'(TABLE_DEPTH) : entries_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[req.entry_index] <= {req.primary_key, req.secondary_key};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            entries_reg <= cfg_wdata;
        end
    end

    // The upper-bound search moves lo past every entry that is less than or equal to the
    // key and pulls hi down to every greater entry. The compare of one probe and the
    // address of the next are worked out in the same cycle.
    assign entry_le = (rd_data_reg <= key_reg);
    assign entry_eq = (rd_data_reg == key_reg);
    assign lo_probe = entry_le ? (pos_t'(mid_reg) + pos_t'(1)) : lo_reg;
    assign hi_probe = entry_le ? hi_reg : pos_t'(mid_reg);
    assign mid_sum  = {1'b0, lo_probe} + {1'b0, hi_probe};

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        hit_next   = hit_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg;
        load_out   = 1'b0;
        req.ready  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (req.cmd == CMD_SEARCH))
                begin
                    key_next = {req.primary_key, req.secondary_key};
                    hit_next = 1'b0;
                    lo_next  = '0;
                    hi_next  = len;
                    if (len != '0)
                    begin
                        // First probe sits at the middle of the whole range.
                        mid_next   = len[ADDR_W:1];
                        rd_en      = 1'b1;
                        rd_addr    = len[ADDR_W:1];
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        // An empty table answers at once: not found, position zero.
                        state_next = ST_DONE;
                    end
                end
            end

            ST_PROBE:
            begin
                lo_next  = lo_probe;
                hi_next  = hi_probe;
                hit_next = hit_reg || (entry_le && entry_eq);
                if (lo_probe < hi_probe)
                begin
                    mid_next = mid_sum[ADDR_W:1];
                    rd_en    = 1'b1;
                    rd_addr  = mid_sum[ADDR_W:1];
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Wait here only while an earlier result is still unclaimed.
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        hit_reg <= hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // On a hit, lo has stepped one past the last equal entry.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg    <= hit_reg;
            position_reg <= lo_reg - pos_t'(hit_reg);
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = found_reg;
    assign rsp.position = position_reg;

    // A probe is only ever in flight over a nonempty range, at an address inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> ((lo_reg < hi_reg) && (pos_t'(mid_reg) < hi_reg)
                                     && (pos_t'(mid_reg) >= lo_reg)))
    else $error("probe outside the search range");

    // A hit can only have been recorded after lo moved past an equal entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && hit_reg) |-> (lo_reg != '0))
    else $error("hit recorded with lo at zero");

    // A finished search waits while the result register is still held by the sink.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
    else $error("result register overwritten before it was taken");

    // A result never points beyond the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.position <= pos_t'(TABLE_DEPTH)))
    else $error("result position beyond the table");

endmodule
